// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, ignored while rst_n is low.
`define DCML_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checked at every rising clk edge, reset included.
`define DCML_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

// ===== rtl/core/dcml_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcml_pkg;

  localparam int unsigned PERIOD    = 10;
  localparam int unsigned LOW_DUTY  = 3;
  localparam int unsigned HIGH_DUTY = 7;
  localparam int unsigned ENOUGH    = 3;
  localparam int unsigned TICK_MAX  = 127;
  localparam int unsigned EDGE_SPAN = PERIOD + 2;

  localparam int unsigned STEP_W  = 4;
  localparam int unsigned TICK_W  = 7;
  localparam int unsigned PAT_W   = 3;
  localparam int unsigned UNK_W   = 8;
  localparam int unsigned START_W = 16;

  typedef enum logic [1:0] {
    PAT_NONE,
    PAT_ACTIVE,
    PAT_INACTIVE,
    PAT_ILLEGAL
  } pat_class_t;

  // v within one of centre
  function automatic logic near_value(input logic [TICK_W-1:0] v,
                                      input logic [TICK_W-1:0] centre);
    logic [TICK_W:0] v1;
    logic [TICK_W:0] c1;
    begin
      v1 = {1'b0, v};
      c1 = {1'b0, centre};
      near_value = (v1 + 1'b1 == c1) || (v1 == c1) || (v1 == c1 + 1'b1);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/duty_cycle_mute_link.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Contents
// in_*      in   in_tvalid/in_tready   one tick: unmute_request, line_in
// out_*     out  out_tvalid/out_tready one result: line_out, unmute_cmd, mute_cmd
// cfg_*     in   cfg_wen               startup_timeout_ticks (reloads countdown)
//
// One word per clock sustained while out_tready is high; a word passes the input register, then the result register.
// The whole tick update sits between the input register and the result register.
// A stalled output holds its word; the input register keeps taking words while the
// result register can move, so the two sides are decoupled by one stage.
// rst_n is synchronous, active low; all link state returns to its idle values.

module duty_cycle_mute_link (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] unmute_request, [1] line_in, [7:2] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] line_out, [1] unmute_cmd, [2] mute_cmd, [7:3] zero
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [dcml_pkg::STEP_W-1:0] PERIOD_C =
    dcml_pkg::STEP_W'(dcml_pkg::PERIOD);
  localparam logic [dcml_pkg::STEP_W-1:0] LOW_C  = dcml_pkg::STEP_W'(dcml_pkg::LOW_DUTY);
  localparam logic [dcml_pkg::STEP_W-1:0] HIGH_C = dcml_pkg::STEP_W'(dcml_pkg::HIGH_DUTY);
  localparam logic [dcml_pkg::STEP_W-1:0] SPAN_C = dcml_pkg::STEP_W'(dcml_pkg::EDGE_SPAN);
  localparam logic [dcml_pkg::TICK_W-1:0] TMAX_C = dcml_pkg::TICK_W'(dcml_pkg::TICK_MAX);
  localparam logic [dcml_pkg::TICK_W-1:0] TLOW_C = dcml_pkg::TICK_W'(dcml_pkg::LOW_DUTY);
  localparam logic [dcml_pkg::TICK_W-1:0] THIGH_C = dcml_pkg::TICK_W'(dcml_pkg::HIGH_DUTY);
  localparam logic [dcml_pkg::PAT_W-1:0]  ENOUGH_C = dcml_pkg::PAT_W'(dcml_pkg::ENOUGH);
  localparam logic [dcml_pkg::UNK_W-1:0]  UENOUGH_C = dcml_pkg::UNK_W'(dcml_pkg::ENOUGH);

  // input register
  logic s1_valid_r;
  logic s1_req_r;
  logic s1_line_r;

  // result register
  logic out_valid_r;
  logic out_line_r;
  logic out_unmute_r;
  logic out_mute_r;

  // link state
  logic [dcml_pkg::STEP_W-1:0]  period_step_r, period_step_nxt;
  logic [dcml_pkg::STEP_W-1:0]  duty_now_r, duty_now_nxt;
  logic [dcml_pkg::STEP_W-1:0]  duty_next_r, duty_next_nxt;
  logic                         last_req_valid_r;
  logic                         last_req_r;
  logic                         last_line_valid_r;
  logic                         last_line_r;
  logic [dcml_pkg::TICK_W-1:0]  high_ticks_r, high_ticks_nxt;
  logic [dcml_pkg::TICK_W-1:0]  low_ticks_r, low_ticks_nxt;
  logic [dcml_pkg::STEP_W-1:0]  edge_timeout_r, edge_timeout_nxt;
  logic [dcml_pkg::PAT_W-1:0]   active_count_r, active_count_nxt;
  logic [dcml_pkg::PAT_W-1:0]   inactive_count_r, inactive_count_nxt;
  logic [dcml_pkg::UNK_W-1:0]   unknown_count_r, unknown_count_nxt;
  logic [dcml_pkg::START_W-1:0] countdown_r, countdown_nxt;

  logic adv;
  logic commit;
  logic tx;
  logic unmute;
  logic mute;
  dcml_pkg::pat_class_t pat;

  assign adv       = !out_valid_r || out_tready;
  assign commit    = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_mute_r, out_unmute_r, out_line_r};

  always_comb begin
    logic [dcml_pkg::STEP_W-1:0] step_inc;
    logic                        is_edge;
    step_inc = period_step_r + 1'b1;

    // transmitter
    duty_next_nxt = duty_next_r;
    if (!last_req_valid_r || s1_req_r != last_req_r) begin
      duty_next_nxt = s1_req_r ? HIGH_C : LOW_C;
    end
    tx = period_step_r < duty_now_r;
    period_step_nxt = step_inc;
    duty_now_nxt    = duty_now_r;
    if (step_inc >= PERIOD_C) begin
      period_step_nxt = '0;
      duty_now_nxt    = duty_next_nxt;
    end

    // detector
    countdown_nxt = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;

    high_ticks_nxt = high_ticks_r;
    low_ticks_nxt  = low_ticks_r;
    if (s1_line_r && high_ticks_r < TMAX_C) begin
      high_ticks_nxt = high_ticks_r + 1'b1;
    end
    if (!s1_line_r && low_ticks_r < TMAX_C) begin
      low_ticks_nxt = low_ticks_r + 1'b1;
    end

    is_edge = !last_line_valid_r || s1_line_r != last_line_r;
    pat = dcml_pkg::PAT_NONE;
    if (is_edge && s1_line_r) begin
      if (dcml_pkg::near_value(high_ticks_nxt, THIGH_C) &&
          dcml_pkg::near_value(low_ticks_nxt, TLOW_C)) begin
        pat = dcml_pkg::PAT_ACTIVE;
      end else if (dcml_pkg::near_value(high_ticks_nxt, TLOW_C) &&
                   dcml_pkg::near_value(low_ticks_nxt, THIGH_C)) begin
        pat = dcml_pkg::PAT_INACTIVE;
      end else begin
        pat = dcml_pkg::PAT_ILLEGAL;
      end
    end

    unmute             = 1'b0;
    mute               = 1'b0;
    active_count_nxt   = active_count_r;
    inactive_count_nxt = inactive_count_r;
    unknown_count_nxt  = unknown_count_r;
    edge_timeout_nxt   = is_edge ? SPAN_C : edge_timeout_r;

    case (pat)
      dcml_pkg::PAT_ACTIVE: begin
        inactive_count_nxt = '0;
        unknown_count_nxt  = '0;
        if (active_count_r < ENOUGH_C) begin
          active_count_nxt = active_count_r + 1'b1;
        end else if (active_count_r == ENOUGH_C) begin
          unmute           = 1'b1;
          active_count_nxt = active_count_r + 1'b1;
        end
      end
      dcml_pkg::PAT_INACTIVE: begin
        active_count_nxt  = '0;
        unknown_count_nxt = '0;
        if (inactive_count_r < ENOUGH_C) begin
          inactive_count_nxt = inactive_count_r + 1'b1;
        end else if (inactive_count_r == ENOUGH_C) begin
          mute               = 1'b1;
          inactive_count_nxt = inactive_count_r + 1'b1;
        end
      end
      dcml_pkg::PAT_ILLEGAL: begin
        active_count_nxt   = '0;
        inactive_count_nxt = '0;
        if (unknown_count_r < UENOUGH_C) begin
          unknown_count_nxt = unknown_count_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (pat != dcml_pkg::PAT_NONE) begin
      high_ticks_nxt = '0;
      low_ticks_nxt  = '0;
    end

    // no edge for a whole span
    if (edge_timeout_nxt != '0) begin
      edge_timeout_nxt = edge_timeout_nxt - 1'b1;
    end
    if (edge_timeout_nxt == '0) begin
      edge_timeout_nxt = SPAN_C;
      if (unknown_count_nxt < UENOUGH_C) begin
        unknown_count_nxt = unknown_count_nxt + 1'b1;
      end
    end

    // fallback unmute, count wraps
    if (countdown_nxt == '0 && unknown_count_nxt >= UENOUGH_C) begin
      unmute             = 1'b1;
      unknown_count_nxt  = unknown_count_nxt + 1'b1;
      active_count_nxt   = '0;
      inactive_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      period_step_r     <= '0;
      duty_now_r        <= LOW_C;
      duty_next_r       <= LOW_C;
      last_req_valid_r  <= 1'b0;
      last_req_r        <= 1'b0;
      last_line_valid_r <= 1'b0;
      last_line_r       <= 1'b0;
      high_ticks_r      <= '0;
      low_ticks_r       <= '0;
      edge_timeout_r    <= dcml_pkg::STEP_W'(10);
      active_count_r    <= '0;
      inactive_count_r  <= '0;
      unknown_count_r   <= '0;
      countdown_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (commit) begin
        period_step_r     <= period_step_nxt;
        duty_now_r        <= duty_now_nxt;
        duty_next_r       <= duty_next_nxt;
        last_req_valid_r  <= 1'b1;
        last_req_r        <= s1_req_r;
        last_line_valid_r <= 1'b1;
        last_line_r       <= s1_line_r;
        high_ticks_r      <= high_ticks_nxt;
        low_ticks_r       <= low_ticks_nxt;
        edge_timeout_r    <= edge_timeout_nxt;
        active_count_r    <= active_count_nxt;
        inactive_count_r  <= inactive_count_nxt;
        unknown_count_r   <= unknown_count_nxt;
      end
      if (cfg_wen) begin
        countdown_r <= cfg_wdata;
      end else if (commit) begin
        countdown_r <= countdown_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r  <= in_tdata[0];
      s1_line_r <= in_tdata[1];
    end
    if (commit) begin
      out_line_r   <= tx;
      out_unmute_r <= unmute;
      out_mute_r   <= mute;
    end
  end

  `include "assert_macros.svh"

  `DCML_ASSERT(a_cmd_exclusive, out_valid_r |-> !(out_unmute_r && out_mute_r), "both cmds")
  `DCML_ASSERT(a_step_range, period_step_r < PERIOD_C, "period step out of range")
  `DCML_ASSERT(a_timeout_range, edge_timeout_r != '0 && edge_timeout_r <= SPAN_C, "bad timeout")
  `DCML_ASSERT(a_pattern_one_side, active_count_r == '0 || inactive_count_r == '0, "both counts")
  `DCML_ASSERT(a_no_commit_state_hold, !commit && !cfg_wen |=> $stable(unknown_count_r), "drift")

endmodule

`default_nettype wire
